[rtl/core/csq_pkg.sv]
package csq_pkg;

  localparam int ELAPSED_WIDTH = 16;
  localparam int LIMIT_W       = 8;
  localparam int PERIOD_W      = 16;
  // integrator holds -limit..+limit, one bit more than the limit plus sign
  localparam int CNT_W         = LIMIT_W + 1;
  localparam int CMP_W         = (PERIOD_W > ELAPSED_WIDTH) ? PERIOD_W : ELAPSED_WIDTH;

  localparam int APB_DATA_W    = 32;
  localparam int APB_ADDR_W    = 3;

  typedef enum logic {
    REG_LIMIT  = 1'b0,
    REG_PERIOD = 1'b1
  } csq_reg_t;

  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(150);
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(500);

endpackage

[rtl/core/csq_in_if.sv]
interface csq_in_if import csq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     power_present;
  logic                     charging_active;
  logic                     full_active;
  logic [ELAPSED_WIDTH-1:0] elapsed_ms;

  modport source (output valid, output power_present, output charging_active,
                  output full_active, output elapsed_ms, input ready);
  modport sink (input valid, input power_present, input charging_active,
                input full_active, input elapsed_ms, output ready);
endinterface

[rtl/core/csq_out_if.sv]
interface csq_out_if;
  logic valid;
  logic ready;
  logic power_status;
  logic charging_status;
  logic full_status;
  logic connect_event;
  logic remove_event;
  logic full_event;

  modport source (output valid, output power_status, output charging_status,
                  output full_status, output connect_event, output remove_event,
                  output full_event, input ready);
  modport sink (input valid, input power_status, input charging_status,
                input full_status, input connect_event, input remove_event,
                input full_event, output ready);
endinterface

[rtl/core/charger_status_qualifier.sv]
// Charger status qualifier. Each input beat is one tick: the power, charging
// and full pin levels plus the milliseconds since the last tick. Every tick
// yields exactly one result beat with the qualified power, charging and full
// status bits and the connect, remove and full event pulses. A tick is taken
// every clock cycle while the result side keeps up. A tick passes through the
// input register, then the state update into the result register, from which
// its result beat is driven. A stalled result beat holds the state, so the
// input takes one more tick and then stalls until it drains. The user is to
// write the registers at byte 0 (integrator limit) and byte 4 (decision period
// in ms) over APB only while no tick is in flight; the block does not enforce it.
module charger_status_qualifier import csq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  csq_in_if.sink                in_ch,
  csq_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  function automatic logic signed [CNT_W-1:0] integrate(
    input logic signed [CNT_W-1:0] acc,
    input logic                    up,
    input logic [LIMIT_W-1:0]      lim
  );
    logic signed [CNT_W:0] step;
    logic signed [CNT_W:0] sum;
    logic signed [CNT_W:0] hi;
    logic signed [CNT_W:0] lo;
    logic signed [CNT_W:0] res;
    step = up ? (CNT_W+1)'(1) : {(CNT_W+1){1'b1}};
    sum  = $signed({acc[CNT_W-1], acc}) + step;
    hi   = $signed({2'b00, lim});
    lo   = -hi;
    if (sum > hi) res = hi;
    else if (sum < lo) res = lo;
    else res = sum;
    return res[CNT_W-1:0];
  endfunction

  // configuration
  logic [LIMIT_W-1:0]  limit_r;
  logic [PERIOD_W-1:0] period_r;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RST;
      period_r <= PERIOD_RST;
    end else if (cfg_wr) begin
      case (csq_reg_t'(paddr[2]))
        REG_LIMIT:  limit_r  <= pwdata[LIMIT_W-1:0];
        REG_PERIOD: period_r <= pwdata[PERIOD_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (csq_reg_t'(paddr[2]))
      REG_LIMIT:  prdata = APB_DATA_W'(limit_r);
      REG_PERIOD: prdata = APB_DATA_W'(period_r);
      default:    prdata = '0;
    endcase
  end

  // input register
  logic                     s1_v_r;
  logic                     s1_pwr_r;
  logic                     s1_chg_r;
  logic                     s1_ful_r;
  logic [ELAPSED_WIDTH-1:0] s1_dt_r;
  logic                     s1_adv;
  logic                     take;
  logic                     out_v_r;

  assign s1_adv      = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_adv;
  assign take        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (take) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pwr_r <= in_ch.power_present;
      s1_chg_r <= in_ch.charging_active;
      s1_ful_r <= in_ch.full_active;
      s1_dt_r  <= in_ch.elapsed_ms;
    end
  end

  // qualifier state
  logic                    power_seen_r, power_seen_nxt;
  logic                    connected_r, connected_nxt;
  logic                    full_latched_r, full_latched_nxt;
  logic signed [CNT_W-1:0] chg_cnt_r, chg_cnt_nxt;
  logic signed [CNT_W-1:0] ful_cnt_r, ful_cnt_nxt;
  logic [PERIOD_W-1:0]     chg_cd_r, chg_cd_nxt;
  logic [PERIOD_W-1:0]     ful_cd_r, ful_cd_nxt;
  logic                    chg_bit_r, chg_bit_nxt;
  logic                    ful_bit_r, ful_bit_nxt;
  logic                    ev_conn, ev_rem, ev_full;
  logic                    chg_exp, ful_exp;

  always_comb begin
    power_seen_nxt   = power_seen_r;
    connected_nxt    = connected_r;
    full_latched_nxt = full_latched_r;
    ev_conn          = 1'b0;
    ev_rem           = 1'b0;
    ev_full          = 1'b0;

    if (s1_pwr_r != power_seen_r) begin
      power_seen_nxt = s1_pwr_r;
      if (s1_pwr_r) begin
        if (!connected_r) begin
          connected_nxt = 1'b1;
          ev_conn       = 1'b1;
        end
      end else begin
        ev_rem           = connected_r;
        connected_nxt    = 1'b0;
        full_latched_nxt = 1'b0;
      end
    end

    // countdown expires once it would reach zero or below
    chg_cnt_nxt = integrate(chg_cnt_r, s1_chg_r, limit_r);
    chg_exp     = CMP_W'(chg_cd_r) <= CMP_W'(s1_dt_r);
    chg_cd_nxt  = chg_exp ? period_r : chg_cd_r - PERIOD_W'(s1_dt_r);
    chg_bit_nxt = chg_exp ? (chg_cnt_nxt > 0) : chg_bit_r;

    ful_cnt_nxt = integrate(ful_cnt_r, s1_ful_r, limit_r);
    ful_exp     = CMP_W'(ful_cd_r) <= CMP_W'(s1_dt_r);
    ful_cd_nxt  = ful_exp ? period_r : ful_cd_r - PERIOD_W'(s1_dt_r);
    ful_bit_nxt = ful_exp ? (ful_cnt_nxt > 0) : ful_bit_r;

    if (ful_exp && ful_bit_nxt && !full_latched_nxt) begin
      full_latched_nxt = 1'b1;
      ev_full          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_seen_r   <= 1'b0;
      connected_r    <= 1'b0;
      full_latched_r <= 1'b0;
      chg_cnt_r      <= '0;
      ful_cnt_r      <= '0;
      chg_cd_r       <= '0;
      ful_cd_r       <= '0;
      chg_bit_r      <= 1'b0;
      ful_bit_r      <= 1'b0;
    end else if (s1_adv) begin
      power_seen_r   <= power_seen_nxt;
      connected_r    <= connected_nxt;
      full_latched_r <= full_latched_nxt;
      chg_cnt_r      <= chg_cnt_nxt;
      ful_cnt_r      <= ful_cnt_nxt;
      chg_cd_r       <= chg_cd_nxt;
      ful_cd_r       <= ful_cd_nxt;
      chg_bit_r      <= chg_bit_nxt;
      ful_bit_r      <= ful_bit_nxt;
    end
  end

  // result register
  logic out_pwr_r, out_chg_r, out_ful_r, out_conn_r, out_rem_r, out_fev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pwr_r  <= power_seen_nxt;
      out_chg_r  <= chg_bit_nxt;
      out_ful_r  <= ful_bit_nxt;
      out_conn_r <= ev_conn;
      out_rem_r  <= ev_rem;
      out_fev_r  <= ev_full;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.power_status    = out_pwr_r;
  assign out_ch.charging_status = out_chg_r;
  assign out_ch.full_status     = out_ful_r;
  assign out_ch.connect_event   = out_conn_r;
  assign out_ch.remove_event    = out_rem_r;
  assign out_ch.full_event      = out_fev_r;

`ifndef NO_ASSERTIONS
  a_conn_rem_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_conn_r && out_rem_r))
    else $error("connect and remove in the same beat");

  a_conn_power: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_conn_r) |-> out_pwr_r)
    else $error("connect event without power");

  a_rem_power: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_rem_r) |-> !out_pwr_r)
    else $error("remove event with power still present");

  a_full_event_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_fev_r) |-> (out_ful_r && full_latched_r))
    else $error("full event without full decision and latch");
`endif

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import csq_pkg::*;

  typedef struct packed {
    logic                     pwr;
    logic                     chg;
    logic                     ful;
    logic [ELAPSED_WIDTH-1:0] dt;
  } tick_t;

  typedef struct packed {
    logic power_status;
    logic charging_status;
    logic full_status;
    logic connect_event;
    logic remove_event;
    logic full_event;
  } status_t;

  typedef enum logic {
    ROW_TICK = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    csq_reg_t    sel;
    logic [15:0] value;
    tick_t       tick;
    logic        typed;
    status_t     status;
  } row_t;

  localparam int N_ROWS     = 28;
  localparam int N_PHASES   = 6;
  localparam int PHASE_LEN  = 220;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  csq_in_if  in_ch ();
  csq_out_if out_ch ();

  charger_status_qualifier DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // directed ticks: reset state, extremes, zero limit and period,
  // full event with no connection; typed status only where obvious
  row_t directed_rows [N_ROWS] = '{
    '{ROW_TICK, REG_LIMIT,  16'd0,     '{1'b0, 1'b0, 1'b0, 16'd0},     1'b1, 6'b000000},
    '{ROW_TICK, REG_LIMIT,  16'd0,     '{1'b1, 1'b1, 1'b1, 16'd0},     1'b1, 6'b100100},
    '{ROW_TICK, REG_LIMIT,  16'd0,     '{1'b1, 1'b1, 1'b1, 16'd65535}, 1'b1, 6'b111001},
    '{ROW_TICK, REG_LIMIT,  16'd0,     '{1'b0, 1'b0, 1'b0, 16'd0},     1'b1, 6'b011010},
    '{ROW_TICK, REG_LIMIT,  16'd0,     '{1'b1, 1'b1, 1'b1, 16'd499},   1'b1, 6'b111100},
    '{ROW_TICK, REG_LIMIT,  16'd0,     '{1'b1, 1'b0, 1'b1, 16'd1},     1'b1, 6'b101001},
    '{ROW_CFG,  REG_LIMIT,  16'd0,     '0, 1'b0, '0},
    '{ROW_CFG,  REG_PERIOD, 16'd0,     '0, 1'b0, '0},
    '{ROW_TICK, REG_LIMIT,  16'd0,     '{1'b1, 1'b1, 1'b1, 16'd0},     1'b0, '0},
    '{ROW_TICK, REG_LIMIT,  16'd0,     '{1'b1, 1'b1, 1'b1, 16'd65535}, 1'b0, '0},
    '{ROW_TICK, REG_LIMIT,  16'd0,     '{1'b1, 1'b1, 1'b0, 16'd0},     1'b0, '0},
    '{ROW_TICK, REG_LIMIT,  16'd0,     '{1'b0, 1'b0, 1'b0, 16'd1},     1'b0, '0},
    '{ROW_CFG,  REG_LIMIT,  16'd255,   '0, 1'b0, '0},
    '{ROW_CFG,  REG_PERIOD, 16'd65535, '0, 1'b0, '0},
    '{ROW_TICK, REG_LIMIT,  16'd0,     '{1'b1, 1'b1, 1'b1, 16'd65535}, 1'b0, '0},
    '{ROW_TICK, REG_LIMIT,  16'd0,     '{1'b1, 1'b1, 1'b1, 16'd65534}, 1'b0, '0},
    '{ROW_TICK, REG_LIMIT,  16'd0,     '{1'b1, 1'b1, 1'b1, 16'd1},     1'b0, '0},
    '{ROW_TICK, REG_LIMIT,  16'd0,     '{1'b1, 1'b0, 1'b0, 16'd65535}, 1'b0, '0},
    '{ROW_CFG,  REG_LIMIT,  16'd1,     '0, 1'b0, '0},
    '{ROW_CFG,  REG_PERIOD, 16'd1,     '0, 1'b0, '0},
    '{ROW_TICK, REG_LIMIT,  16'd0,     '{1'b0, 1'b0, 1'b1, 16'd1},     1'b0, '0},
    '{ROW_TICK, REG_LIMIT,  16'd0,     '{1'b0, 1'b0, 1'b1, 16'd1},     1'b0, '0},
    '{ROW_TICK, REG_LIMIT,  16'd0,     '{1'b1, 1'b0, 1'b0, 16'd0},     1'b0, '0},
    '{ROW_TICK, REG_LIMIT,  16'd0,     '{1'b0, 1'b1, 1'b1, 16'd7},     1'b0, '0},
    '{ROW_TICK, REG_LIMIT,  16'd0,     '{1'b0, 1'b1, 1'b1, 16'd32768}, 1'b0, '0},
    '{ROW_TICK, REG_LIMIT,  16'd0,     '{1'b0, 1'b0, 1'b0, 16'd255},   1'b0, '0},
    '{ROW_CFG,  REG_LIMIT,  16'd150,   '0, 1'b0, '0},
    '{ROW_CFG,  REG_PERIOD, 16'd500,   '0, 1'b0, '0}
  };

  string field_names [6] = '{"power_status", "charging_status", "full_status",
                             "connect_event", "remove_event", "full_event"};

  // qualifier model state and its register copies
  logic [LIMIT_W-1:0]  limit_q;
  logic [PERIOD_W-1:0] period_q;
  logic                seen_power;
  logic                linked;
  logic                full_held;
  int                  chg_acc;
  int                  full_acc;
  longint              chg_timer;
  longint              ful_countdown;
  logic                chg_bit;
  logic                full_bit_q;

  status_t expected_status [$];
  int      fail_count;
  int      burst_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int clamp_step(int acc, logic up, int lim);
    acc += up ? 1 : -1;
    if (acc > lim)
      acc = lim;
    else if (acc < -lim)
      acc = -lim;
    return acc;
  endfunction

  function automatic status_t qualify_tick(tick_t t);
    status_t s;
    int      lim;
    s   = '0;
    lim = int'(limit_q);
    if (t.pwr != seen_power) begin
      seen_power = t.pwr;
      if (t.pwr) begin
        if (!linked) begin
          linked          = 1'b1;
          s.connect_event = 1'b1;
        end
      end else begin
        if (linked)
          s.remove_event = 1'b1;
        linked    = 1'b0;
        full_held = 1'b0;
      end
    end
    chg_acc   = clamp_step(chg_acc, t.chg, lim);
    chg_timer = chg_timer - longint'(t.dt);
    if (chg_timer <= 0) begin
      chg_timer = longint'(period_q);
      chg_bit   = chg_acc > 0;
    end
    full_acc      = clamp_step(full_acc, t.ful, lim);
    ful_countdown = ful_countdown - longint'(t.dt);
    if (ful_countdown <= 0) begin
      ful_countdown = longint'(period_q);
      full_bit_q    = full_acc > 0;
      if (full_bit_q && !full_held) begin
        full_held    = 1'b1;
        s.full_event = 1'b1;
      end
    end
    s.power_status    = seen_power;
    s.charging_status = chg_bit;
    s.full_status     = full_bit_q;
    return s;
  endfunction

  function automatic int run_length(int lim);
    if ($urandom_range(0, 9) < 6)
      return $urandom_range(1, 12);
    return $urandom_range(1, 2 * lim + 20);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic push_tick(tick_t t, logic typed, status_t status);
    status_t s;
    int      gap;
    in_ch.valid           = 1'b1;
    in_ch.power_present   = t.pwr;
    in_ch.charging_active = t.chg;
    in_ch.full_active     = t.ful;
    in_ch.elapsed_ms      = t.dt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    s = qualify_tick(t);
    expected_status.push_back(typed ? status : s);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(0, 30);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic settle_idle();
    in_ch.valid = 1'b0;
    while (expected_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(csq_reg_t sel, int unsigned value);
    logic [APB_DATA_W-1:0] want;
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = APB_ADDR_W'(4 * int'(sel));
    pwdata  = APB_DATA_W'(value);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (sel == REG_LIMIT)
      limit_q = value[LIMIT_W-1:0];
    else
      period_q = value[PERIOD_W-1:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    psel = 1'b1;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    want = (sel == REG_LIMIT) ? APB_DATA_W'(limit_q) : APB_DATA_W'(period_q);
    if (prdata !== want) begin
      $display("%0t: %s readback expected %0d got %0d", $time, sel.name(), want, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // result receiver: stall pattern switches mode every so often
  initial begin : sink_stalls
    int mode;
    int left;
    int cyc;
    mode         = 0;
    left         = 0;
    cyc          = 0;
    out_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 200);
      end
      left--;
      cyc++;
      case (mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = 1'($urandom_range(0, 1));
        2: out_ch.ready = ($urandom_range(0, 5) == 0);
        default: out_ch.ready = (cyc % 5) != 0;
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    status_t got;
    status_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.power_status, out_ch.charging_status, out_ch.full_status,
             out_ch.connect_event, out_ch.remove_event, out_ch.full_event};
      if (expected_status.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none got %b", $time, got);
        fail_count++;
      end else begin
        want = expected_status.pop_front();
        for (int b = 5; b >= 0; b--) begin
          if (got[b] !== want[b]) begin
            $display("%0t: %s expected %0d got %0d", $time, field_names[5-b], want[b], got[b]);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    tick_t                t;
    int unsigned          lim;
    int unsigned          per;
    int                   sel;
    logic                 lvl_pwr;
    logic                 lvl_chg;
    logic                 lvl_ful;
    int                   run_pwr;
    int                   run_chg;
    int                   run_ful;

    rst_n                 = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    in_ch.valid           = 1'b0;
    in_ch.power_present   = 1'b0;
    in_ch.charging_active = 1'b0;
    in_ch.full_active     = 1'b0;
    in_ch.elapsed_ms      = '0;
    fail_count            = 0;
    burst_left            = 0;
    limit_q               = LIMIT_RST;
    period_q              = PERIOD_RST;
    seen_power            = 1'b0;
    linked                = 1'b0;
    full_held             = 1'b0;
    chg_acc               = 0;
    full_acc              = 0;
    chg_timer             = 0;
    ful_countdown         = 0;
    chg_bit               = 1'b0;
    full_bit_q            = 1'b0;
    lvl_pwr               = 1'b0;
    lvl_chg               = 1'b0;
    lvl_ful               = 1'b0;
    run_pwr               = 0;
    run_chg               = 0;
    run_ful               = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < N_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        settle_idle();
        write_register(directed_rows[r].sel, 32'(directed_rows[r].value));
      end else begin
        push_tick(directed_rows[r].tick, directed_rows[r].typed, directed_rows[r].status);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle_idle();
      case (ph)
        0: begin lim = $urandom_range(1, 8);   per = $urandom_range(1, 64);    end
        1: begin lim = 1;                      per = 1;                        end
        2: begin lim = 255;                    per = 65535;                    end
        3: begin lim = 0;                      per = 0;                        end
        4: begin lim = $urandom_range(0, 255); per = $urandom_range(0, 65535); end
        default: begin lim = $urandom_range(2, 20); per = $urandom_range(10, 300); end
      endcase
      write_register(REG_LIMIT, lim);
      write_register(REG_PERIOD, per);
      for (int n = 0; n < PHASE_LEN; n++) begin
        // pins hold steady for runs so the integrators can saturate
        if (run_pwr == 0) begin
          lvl_pwr = ($urandom_range(0, 3) != 0) ? ~lvl_pwr : 1'($urandom_range(0, 1));
          run_pwr = $urandom_range(1, 40);
        end
        if (run_chg == 0) begin
          lvl_chg = ($urandom_range(0, 3) != 0) ? ~lvl_chg : 1'($urandom_range(0, 1));
          run_chg = run_length(int'(limit_q));
        end
        if (run_ful == 0) begin
          lvl_ful = ($urandom_range(0, 3) != 0) ? ~lvl_ful : 1'($urandom_range(0, 1));
          run_ful = run_length(int'(limit_q));
        end
        run_pwr--;
        run_chg--;
        run_ful--;
        // single-tick glitches on top of the held levels
        t.pwr = lvl_pwr ^ ($urandom_range(0, 19) == 0);
        t.chg = lvl_chg ^ ($urandom_range(0, 9) == 0);
        t.ful = lvl_ful ^ ($urandom_range(0, 9) == 0);
        sel = $urandom_range(0, 99);
        if (sel < 70)
          t.dt = ELAPSED_WIDTH'($urandom_range(0, int'(period_q) / 8 + 2));
        else if (sel < 85)
          t.dt = ELAPSED_WIDTH'($urandom_range(0, int'(period_q) + 2));
        else
          t.dt = ELAPSED_WIDTH'($urandom);
        push_tick(t, 1'b0, '0);
      end
    end

    in_ch.valid = 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/csq_pkg.sv
rtl/core/csq_in_if.sv
rtl/core/csq_out_if.sv
rtl/core/charger_status_qualifier.sv
bench/testbench.sv
